// ===== sv/rfv_pkg.sv =====
// Package: shared types and constants for the random-forest vote classifier.
`default_nettype none
package rfv_pkg;

    localparam int TREES_DEF      = 32;
    localparam int NODES_DEF      = 64;
    localparam int COORD_BITS_DEF = 32;

    localparam logic [5:0] TREES_IN_USE_RESET = 6'd30;

    localparam logic       OP_WRITE    = 1'b0;
    localparam logic       OP_CLASSIFY = 1'b1;

    localparam logic [1:0] CLASS_ONE = 2'd1;
    localparam logic [1:0] CLASS_TWO = 2'd2;

    typedef enum logic [2:0] {
        KIND_EMPTY   = 3'd0,
        KIND_LEAF1   = 3'd1,
        KIND_LEAF2   = 3'd2,
        KIND_SPLIT_X = 3'd3,
        KIND_SPLIT_Y = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_WALK,
        C_DONE
    } cell_state_t;

    typedef enum logic [1:0] {
        T_CLEAR,
        T_IDLE,
        T_RUN,
        T_OUT
    } top_state_t;

endpackage
`default_nettype wire

// ===== sv/rfv_if.sv =====
// Interfaces: item, result and configuration channels.
`default_nettype none
interface rfv_item_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [4:0]         tree_index;
    logic [5:0]         node_index;
    logic [2:0]         node_kind;
    logic signed [31:0] split_threshold;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    modport source (output valid, op, tree_index, node_index, node_kind,
                    split_threshold, point_x, point_y, input ready);
    modport sink   (input valid, op, tree_index, node_index, node_kind,
                    split_threshold, point_x, point_y, output ready);
endinterface

interface rfv_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] predicted_class;
    logic [5:0] votes_class_one;
    logic [5:0] votes_class_two;
    modport source (output valid, predicted_class, votes_class_one, votes_class_two,
                    input ready);
    modport sink   (input valid, predicted_class, votes_class_one, votes_class_two,
                    output ready);
endinterface

interface rfv_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/rfv_cell.sv =====
// One tree cell: holds one tree's nodes, walks it and passes point and votes on.
`default_nettype none
module rfv_cell #(
    parameter int NODES      = rfv_pkg::NODES_DEF,
    parameter int COORD_BITS = rfv_pkg::COORD_BITS_DEF,
    parameter int VW         = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(NODES)-1:0]     wr_node,
    input  wire rfv_pkg::kind_t               wr_kind,
    input  wire logic signed [COORD_BITS-1:0] wr_thr,
    input  wire logic                         enable,
    input  wire logic                         in_valid,
    input  wire logic signed [COORD_BITS-1:0] in_x,
    input  wire logic signed [COORD_BITS-1:0] in_y,
    input  wire logic [VW-1:0]                in_v1,
    input  wire logic [VW-1:0]                in_v2,
    output logic                              out_valid,
    output logic signed [COORD_BITS-1:0]      out_x,
    output logic signed [COORD_BITS-1:0]      out_y,
    output logic [VW-1:0]                     out_v1,
    output logic [VW-1:0]                     out_v2
);
    localparam int NIDX = $clog2(NODES);

    rfv_pkg::kind_t              kind_mem [NODES];
    logic signed [COORD_BITS-1:0] thr_mem [NODES];

    rfv_pkg::kind_t               rd_kind_reg;
    logic signed [COORD_BITS-1:0] rd_thr_reg;

    rfv_pkg::cell_state_t state_reg, state_next;
    logic [NIDX-1:0]      node_reg, node_next;
    logic signed [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic [VW-1:0]        v1_reg, v1_next, v2_reg, v2_next;

    logic signed [COORD_BITS-1:0] coord;
    logic [NIDX+1:0]      child;
    logic                 go_on;

    // rd data for node_next is ready in the next cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kind_mem[wr_node] <= wr_kind;
            thr_mem[wr_node]  <= wr_thr;
        end
        rd_kind_reg <= kind_mem[node_next];
        rd_thr_reg  <= thr_mem[node_next];
    end

    always_comb
    begin
        coord = (rd_kind_reg == rfv_pkg::KIND_SPLIT_Y) ? y_reg : x_reg;
        child = (coord >= rd_thr_reg) ? ({2'b00, node_reg} << 1) + (NIDX+2)'(2)
                                      : ({2'b00, node_reg} << 1) + (NIDX+2)'(1);
        go_on = ((rd_kind_reg == rfv_pkg::KIND_SPLIT_X) ||
                 (rd_kind_reg == rfv_pkg::KIND_SPLIT_Y)) &&
                (32'(child) < NODES);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rfv_pkg::C_IDLE:
            begin
                if (in_valid)
                    state_next = enable ? rfv_pkg::C_WALK : rfv_pkg::C_DONE;
            end
            rfv_pkg::C_WALK:
            begin
                if (!go_on)
                    state_next = rfv_pkg::C_DONE;
            end
            rfv_pkg::C_DONE: state_next = rfv_pkg::C_IDLE;
            default:         state_next = rfv_pkg::C_IDLE;
        endcase
    end

    always_comb
    begin
        node_next = node_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        v1_next   = v1_reg;
        v2_next   = v2_reg;
        unique case (state_reg)
            rfv_pkg::C_IDLE:
            begin
                node_next = '0;
                if (in_valid)
                begin
                    x_next  = in_x;
                    y_next  = in_y;
                    v1_next = in_v1;
                    v2_next = in_v2;
                end
            end
            rfv_pkg::C_WALK:
            begin
                case (rd_kind_reg)
                    rfv_pkg::KIND_LEAF1: v1_next = v1_reg + VW'(1);
                    rfv_pkg::KIND_LEAF2: v2_next = v2_reg + VW'(1);
                    default:
                    begin
                        if (go_on)
                            node_next = NIDX'(child);
                    end
                endcase
            end
            default: node_next = node_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rfv_pkg::C_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        v1_reg   <= v1_next;
        v2_reg   <= v2_next;
    end

    assign out_valid = (state_reg == rfv_pkg::C_DONE);
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_v1    = v1_reg;
    assign out_v2    = v2_reg;

endmodule
`default_nettype wire

// ===== sv/random_forest_vote_classifier_unit.sv =====
// Top level: a chain of tree cells that the point and vote counts travel through.
// Write item: stored into the addressed tree's node store, no result. Classify item: the point
// walks each tree in use in turn and the result is held until taken; one item at a time.
// After reset every node store is cleared to empty; no item is taken until then.
// trees_in_use resets to 30.
`default_nettype none
module random_forest_vote_classifier_unit #(
    parameter int TREES      = rfv_pkg::TREES_DEF,
    parameter int NODES      = rfv_pkg::NODES_DEF,
    parameter int COORD_BITS = rfv_pkg::COORD_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rfv_item_if.sink      item,
    rfv_result_if.source  result,
    rfv_cfg_if.sink       cfg
);
    localparam int NIDX = $clog2(NODES);
    localparam int VW   = $clog2(TREES + 1);

    rfv_pkg::top_state_t state_reg, state_next;
    logic [NIDX-1:0] clr_reg, clr_next;
    logic [5:0]      trees_reg;
    logic [1:0]      cls_reg, cls_next;
    logic [5:0]      v1o_reg, v1o_next, v2o_reg, v2o_next;

    logic                  take;
    logic                  wr_any;
    logic [NIDX-1:0]       wr_node;
    rfv_pkg::kind_t        wr_kind;
    logic signed [COORD_BITS-1:0] wr_thr;

    logic                         cv [TREES+1];
    logic signed [COORD_BITS-1:0] cx [TREES+1];
    logic signed [COORD_BITS-1:0] cy [TREES+1];
    logic [VW-1:0]                c1 [TREES+1];
    logic [VW-1:0]                c2 [TREES+1];

    assign item.ready = (state_reg == rfv_pkg::T_IDLE);
    assign take       = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        if (state_reg == rfv_pkg::T_CLEAR)
        begin
            wr_any  = 1'b1;
            wr_node = clr_reg;
            wr_kind = rfv_pkg::KIND_EMPTY;
            wr_thr  = '0;
        end
        else
        begin
            wr_any  = take && (item.op == rfv_pkg::OP_WRITE) &&
                      (32'(item.node_index) < NODES);
            wr_node = NIDX'(item.node_index);
            wr_kind = (item.node_kind > 3'(rfv_pkg::KIND_SPLIT_Y))
                      ? rfv_pkg::KIND_EMPTY
                      : rfv_pkg::kind_t'(item.node_kind);
            wr_thr  = COORD_BITS'(item.split_threshold);
        end
    end

    assign cv[0] = take && (item.op == rfv_pkg::OP_CLASSIFY);
    assign cx[0] = COORD_BITS'(item.point_x);
    assign cy[0] = COORD_BITS'(item.point_y);
    assign c1[0] = '0;
    assign c2[0] = '0;

    for (genvar i = 0; i < TREES; i++)
    begin : g_cell
        logic wr_en_i;
        assign wr_en_i = wr_any && ((state_reg == rfv_pkg::T_CLEAR) ||
                                    (32'(item.tree_index) == i));
        rfv_cell #(
            .NODES      (NODES),
            .COORD_BITS (COORD_BITS),
            .VW         (VW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en_i),
            .wr_node   (wr_node),
            .wr_kind   (wr_kind),
            .wr_thr    (wr_thr),
            .enable    (32'(trees_reg) > i),
            .in_valid  (cv[i]),
            .in_x      (cx[i]),
            .in_y      (cy[i]),
            .in_v1     (c1[i]),
            .in_v2     (c2[i]),
            .out_valid (cv[i+1]),
            .out_x     (cx[i+1]),
            .out_y     (cy[i+1]),
            .out_v1    (c1[i+1]),
            .out_v2    (c2[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rfv_pkg::T_CLEAR:
            begin
                if (32'(clr_reg) == NODES - 1)
                    state_next = rfv_pkg::T_IDLE;
            end
            rfv_pkg::T_IDLE:
            begin
                if (take && (item.op == rfv_pkg::OP_CLASSIFY))
                    state_next = rfv_pkg::T_RUN;
            end
            rfv_pkg::T_RUN:
            begin
                if (cv[TREES])
                    state_next = rfv_pkg::T_OUT;
            end
            rfv_pkg::T_OUT:
            begin
                if (result.ready)
                    state_next = rfv_pkg::T_IDLE;
            end
            default: state_next = rfv_pkg::T_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next = clr_reg + NIDX'(1);
        cls_next = cls_reg;
        v1o_next = v1o_reg;
        v2o_next = v2o_reg;
        if ((state_reg == rfv_pkg::T_RUN) && cv[TREES])
        begin
            cls_next = (c1[TREES] >= c2[TREES]) ? rfv_pkg::CLASS_ONE : rfv_pkg::CLASS_TWO;
            v1o_next = 6'(c1[TREES]);
            v2o_next = 6'(c2[TREES]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rfv_pkg::T_CLEAR;
            clr_reg   <= '0;
            trees_reg <= rfv_pkg::TREES_IN_USE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg.valid && cfg.ready)
                trees_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
        v1o_reg <= v1o_next;
        v2o_reg <= v2o_next;
    end

    assign result.valid           = (state_reg == rfv_pkg::T_OUT);
    assign result.predicted_class = cls_reg;
    assign result.votes_class_one = v1o_reg;
    assign result.votes_class_two = v2o_reg;

endmodule
`default_nettype wire

// ===== sim/random_forest_vote_classifier_unit_test.sv =====
// Testbench for the random-forest vote classifier: directed and random items, checked.
`default_nettype none
module random_forest_vote_classifier_unit_test;

    logic clk;
    logic rst_n;
    bit   failed;
    bit   no_idle;
    bit   hold_result;

    rfv_item_if   item ();
    rfv_result_if result ();
    rfv_cfg_if    cfg ();

    random_forest_vote_classifier_unit DUT (
        .clk(clk), .rst_n(rst_n), .item(item), .result(result), .cfg(cfg)
    );

    typedef struct packed {
        logic [1:0] predicted_class;
        logic [5:0] votes_class_one;
        logic [5:0] votes_class_two;
    } vote_t;

    rfv_pkg::kind_t     forest_kind [32][64];
    logic signed [31:0] forest_thr [32][64];
    logic [5:0]         tree_count;
    vote_t              pending_votes [$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic vote_t tally_forest(logic signed [31:0] px, logic signed [31:0] py);
        vote_t v;
        int    used;
        int    ones;
        int    twos;
        int    j;
        logic signed [31:0] c;
        ones = 0;
        twos = 0;
        used = (tree_count > 32) ? 32 : tree_count;
        for (int t = 0; t < used; t++)
        begin
            j = 0;
            while (j < 64)
            begin
                if (forest_kind[t][j] == rfv_pkg::KIND_LEAF1)
                begin
                    ones++;
                    break;
                end
                if (forest_kind[t][j] == rfv_pkg::KIND_LEAF2)
                begin
                    twos++;
                    break;
                end
                if (forest_kind[t][j] == rfv_pkg::KIND_SPLIT_X)
                    c = px;
                else if (forest_kind[t][j] == rfv_pkg::KIND_SPLIT_Y)
                    c = py;
                else
                    break;
                j = (c >= forest_thr[t][j]) ? 2 * j + 2 : 2 * j + 1;
            end
        end
        v.predicted_class = (ones >= twos) ? rfv_pkg::CLASS_ONE : rfv_pkg::CLASS_TWO;
        v.votes_class_one = ones[5:0];
        v.votes_class_two = twos[5:0];
        return v;
    endfunction

    // Idle with a chance of 23 in 100 unless a quiet stretch is on.
    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 23);
    endfunction

    // valid stays high after a transfer until the next item or an idle cycle drops it
    task automatic send_item(logic o, logic [4:0] t, logic [5:0] n, logic [2:0] k,
                             logic [31:0] thr, logic [31:0] px, logic [31:0] py);
        while (idle_now())
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid           <= 1'b1;
        item.op              <= o;
        item.tree_index      <= t;
        item.node_index      <= n;
        item.node_kind       <= k;
        item.split_threshold <= thr;
        item.point_x         <= px;
        item.point_y         <= py;
        do
            @(posedge clk);
        while (!item.ready);
        if (o == rfv_pkg::OP_WRITE)
        begin
            forest_kind[t][n] = (k > rfv_pkg::KIND_SPLIT_Y) ? rfv_pkg::KIND_EMPTY
                                                            : rfv_pkg::kind_t'(k);
            forest_thr[t][n]  = thr;
        end
        else
            pending_votes.insert(pending_votes.size(), tally_forest(px, py));
    endtask

    task automatic write_node(int t, int n, rfv_pkg::kind_t k, logic [31:0] thr);
        send_item(rfv_pkg::OP_WRITE, t[4:0], n[5:0], k, thr, $urandom, $urandom);
    endtask

    task automatic classify(logic [31:0] px, logic [31:0] py);
        send_item(rfv_pkg::OP_CLASSIFY, 5'($urandom), 6'($urandom), 3'($urandom),
                  $urandom, px, py);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        item.valid <= 1'b0;
        while (pending_votes.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    task automatic set_tree_count(logic [5:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid  <= 1'b0;
        tree_count = value;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(8) << 16;
            default: return $urandom;
        endcase
    endfunction

    // Random tree of small depth; split thresholds drawn near the point range.
    task automatic build_tree(int t);
        int n;
        for (n = 0; n < 15; n++)
        begin
            if (n >= 7)
                write_node(t, n, ($urandom_range(1) ? rfv_pkg::KIND_LEAF1
                                                    : rfv_pkg::KIND_LEAF2), $urandom);
            else if ($urandom_range(9) == 0)
                write_node(t, n, rfv_pkg::kind_t'(3'($urandom_range(2))), $urandom);
            else
                write_node(t, n, ($urandom_range(1) ? rfv_pkg::KIND_SPLIT_X
                                                    : rfv_pkg::KIND_SPLIT_Y),
                           rand_coord());
        end
    endtask

    task automatic test_directed();
        // empty forest: class one with no votes
        classify(32'h8000_0000, 32'h7fff_ffff);
        write_node(0, 0, rfv_pkg::KIND_SPLIT_X, 32'h0001_0000);
        write_node(0, 1, rfv_pkg::KIND_LEAF1, 32'h1234_5678);
        write_node(0, 2, rfv_pkg::KIND_LEAF2, 32'hffff_ffff);
        classify(32'h0001_0000, 0);
        classify(32'h0000_ffff, 0);
        classify(32'h7fff_ffff, 32'h8000_0000);
        classify(32'h8000_0000, 32'h7fff_ffff);
        write_node(1, 0, rfv_pkg::KIND_SPLIT_Y, 32'h8000_0000);
        write_node(1, 2, rfv_pkg::KIND_LEAF2, 0);
        classify(0, 32'h8000_0000);
        classify(0, 32'h7fff_ffff);
        send_item(rfv_pkg::OP_WRITE, 5'd2, 6'd0, 3'd7, 32'hdead_beef, 0, 0);
        send_item(rfv_pkg::OP_WRITE, 5'd3, 6'd0, 3'd5, 0, 0, 0);
        write_node(31, 63, rfv_pkg::KIND_SPLIT_X, 32'h7fff_ffff);
        write_node(31, 0, rfv_pkg::KIND_SPLIT_X, 32'h8000_0000);
        // walk off the end of the heap on the far right path
        for (int n = 2; n < 63; n = 2 * n + 2)
            write_node(31, n, rfv_pkg::KIND_SPLIT_X, 32'h8000_0000);
        classify(0, 0);
        write_node(31, 0, rfv_pkg::KIND_EMPTY, 0);
    endtask

    task automatic test_tree_counts();
        for (int t = 0; t < 32; t++)
            write_node(t, 0, ((t % 3) == 0) ? rfv_pkg::KIND_LEAF2 : rfv_pkg::KIND_LEAF1,
                       $urandom);
        set_tree_count(6'd0);
        classify(0, 0);
        set_tree_count(6'd1);
        classify(0, 0);
        set_tree_count(6'd32);
        classify(0, 0);
        set_tree_count(6'd63);
        classify($urandom, $urandom);
        set_tree_count(6'd33);
        classify($urandom, $urandom);
    endtask

    task automatic test_random_forest(logic [5:0] count, int trees, int points);
        set_tree_count(count);
        for (int t = 0; t < trees; t++)
            build_tree($urandom_range(31));
        for (int i = 0; i < points; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(rfv_pkg::OP_WRITE, 5'($urandom), 6'($urandom), 3'($urandom),
                          $urandom, 0, 0);
            else
                classify(rand_coord(), rand_coord());
        end
    endtask

    task automatic test_backpressure();
        hold_result <= 1'b1;
        for (int i = 0; i < 6; i++)
            classify($urandom, $urandom);
        hold_result <= 1'b0;
    endtask

    // Results are popped only from the checking process.
    initial
    begin
        vote_t want;
        int    stall;
        result.ready <= 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                if (pending_votes.size() == 0)
                begin
                    $error("result with nothing pending");
                    failed = 1'b1;
                end
                else
                begin
                    want = pending_votes.pop_front();
                    if (result.predicted_class !== want.predicted_class)
                    begin
                        $error("predicted_class: expected %0d, got %0d",
                               want.predicted_class, result.predicted_class);
                        failed = 1'b1;
                    end
                    if (result.votes_class_one !== want.votes_class_one)
                    begin
                        $error("votes_class_one: expected %0d, got %0d",
                               want.votes_class_one, result.votes_class_one);
                        failed = 1'b1;
                    end
                    if (result.votes_class_two !== want.votes_class_two)
                    begin
                        $error("votes_class_two: expected %0d, got %0d",
                               want.votes_class_two, result.votes_class_two);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_result && stall < 3000)
                stall++;
            else if (!hold_result)
                stall = 0;
            result.ready <= !(hold_result && stall < 3000) && !idle_now();
        end
    end

    initial
    begin
        item.valid           <= 1'b0;
        item.op              <= rfv_pkg::OP_WRITE;
        item.tree_index      <= '0;
        item.node_index      <= '0;
        item.node_kind       <= '0;
        item.split_threshold <= '0;
        item.point_x         <= '0;
        item.point_y         <= '0;
        cfg.valid            <= 1'b0;
        cfg.data             <= '0;
        hold_result          <= 1'b0;
        failed      = 1'b0;
        no_idle     = 1'b0;
        tree_count  = rfv_pkg::TREES_IN_USE_RESET;
        for (int t = 0; t < 32; t++)
            for (int n = 0; n < 64; n++)
            begin
                forest_kind[t][n] = rfv_pkg::KIND_EMPTY;
                forest_thr[t][n]  = '0;
            end
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_tree_counts();
        test_backpressure();
        test_random_forest(6'd32, 12, 150);
        no_idle = 1'b1;
        test_random_forest(6'd7, 4, 100);
        no_idle = 1'b0;
        test_random_forest(6'd20, 4, 120);
        drain();

        if (!failed && pending_votes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
